// ----- design/cmsip_pkg.sv -----
`default_nettype none

package cmsip_pkg;

    // Field widths
    localparam int unsigned ADDR_W  = 24;
    localparam int unsigned BANK_W  = 6;
    localparam int unsigned STAMP_W = 32;

    // Request types
    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_PCM   = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;

    // Write function codes, cpu_address[14:12]
    localparam logic [2:0] FN_RELOAD   = 3'd0;
    localparam logic [2:0] FN_CLEAR    = 3'd1;
    localparam logic [2:0] FN_IRQ_OFF  = 3'd2;
    localparam logic [2:0] FN_IRQ_ON   = 3'd3;
    localparam logic [2:0] FN_PCM_SHFT = 3'd4;
    localparam logic [2:0] FN_PCM_CTRL = 3'd5;
    localparam logic [2:0] FN_BANK_A   = 3'd6;
    localparam logic [2:0] FN_BANK_B   = 3'd7;

    // Bank register select, data[7:6]
    localparam logic [1:0] BANK_6000 = 2'd0;
    localparam logic [1:0] BANK_8000 = 2'd1;
    localparam logic [1:0] BANK_A000 = 2'd2;
    localparam logic [1:0] BANK_CHR  = 2'd3;

    localparam logic [STAMP_W-1:0] PCM_GUARD = 32'd6;
    localparam logic [ADDR_W-1:0]  MASK_RST  = 24'hFF_FFFF;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [15:0]        cpu_address;
        logic [7:0]         write_data;
        logic [STAMP_W-1:0] cycle_stamp;
    } in_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0] pcm_rom_address;
        logic              irq_line;
        logic [BANK_W-1:0] prg_bank_6000;
        logic [BANK_W-1:0] prg_bank_8000;
        logic [BANK_W-1:0] prg_bank_a000;
        logic [BANK_W-1:0] chr_bank_low;
    } out_item_t;

endpackage

`default_nettype wire

// ----- design/cmsip_core.sv -----
`default_nettype none

module cmsip_core
    import cmsip_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [23:0] cfg_wdata,
    input  wire logic        fire,
    input  wire in_item_t    item,
    output out_item_t        result
);

    logic [ADDR_W-1:0]  mask_reg;
    logic [BANK_W-1:0]  bank_reg [4];
    logic [BANK_W-1:0]  bank_next [4];
    logic [ADDR_W-1:0]  saddr_reg, saddr_next;
    logic [7:0]         sctrl_reg, sctrl_next;
    logic [7:0]         count_reg, count_next;
    logic [7:0]         reload_reg, reload_next;
    logic               irq_en_reg, irq_en_next;
    logic               irq_pend_reg, irq_pend_next;
    logic [STAMP_W-1:0] stamp_reg, stamp_next;

    logic [2:0]         fn;
    logic [STAMP_W-1:0] limit;
    logic               stamp_out;
    logic [7:0]         count_tick;

    assign fn         = item.cpu_address[14:12];
    assign limit      = stamp_reg + PCM_GUARD;
    assign stamp_out  = (item.cycle_stamp < stamp_reg) || (item.cycle_stamp > limit);
    assign count_tick = (count_reg == 8'd0) ? reload_reg : count_reg - 8'd1;

    // Next state for one request
    always_comb begin
        bank_next     = bank_reg;
        saddr_next    = saddr_reg;
        sctrl_next    = sctrl_reg;
        count_next    = count_reg;
        reload_next   = reload_reg;
        irq_en_next   = irq_en_reg;
        irq_pend_next = irq_pend_reg;
        stamp_next    = stamp_reg;
        case (item.req_type)
            REQ_WRITE: begin
                if (item.cpu_address[15]) begin
                    unique case (fn) inside
                        FN_RELOAD:   reload_next = item.write_data;
                        FN_CLEAR:    count_next  = 8'd0;
                        FN_IRQ_OFF: begin
                            irq_en_next   = 1'b0;
                            irq_pend_next = 1'b0;
                        end
                        FN_IRQ_ON:   irq_en_next = 1'b1;
                        FN_PCM_SHFT: saddr_next  = {saddr_reg[ADDR_W-2:0],
                                                    item.write_data[7]};
                        FN_PCM_CTRL: sctrl_next  = item.write_data;
                        FN_BANK_A, FN_BANK_B: begin
                            bank_next[item.write_data[7:6]] = item.write_data[BANK_W-1:0];
                        end
                        default: ;
                    endcase
                end
            end
            REQ_PCM: begin
                if (stamp_out) begin
                    stamp_next = item.cycle_stamp;
                    if (sctrl_reg[1]) begin
                        saddr_next = saddr_reg + 24'd1;
                    end
                end
            end
            REQ_TICK: begin
                count_next = count_tick;
                if ((count_tick == 8'd0) && irq_en_reg) begin
                    irq_pend_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Result: address before any advance, the rest after the update
    always_comb begin
        result.pcm_rom_address = saddr_reg & mask_reg;
        result.irq_line        = irq_pend_next;
        result.prg_bank_6000   = bank_next[BANK_6000];
        result.prg_bank_8000   = bank_next[BANK_8000];
        result.prg_bank_a000   = bank_next[BANK_A000];
        result.chr_bank_low    = bank_next[BANK_CHR];
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg     <= MASK_RST;
            bank_reg     <= '{default: '0};
            saddr_reg    <= '0;
            sctrl_reg    <= '0;
            count_reg    <= '0;
            reload_reg   <= '0;
            irq_en_reg   <= 1'b0;
            irq_pend_reg <= 1'b0;
            stamp_reg    <= '0;
        end else begin
            if (cfg_we) begin
                mask_reg <= cfg_wdata;
            end
            if (fire) begin
                bank_reg     <= bank_next;
                saddr_reg    <= saddr_next;
                sctrl_reg    <= sctrl_next;
                count_reg    <= count_next;
                reload_reg   <= reload_next;
                irq_en_reg   <= irq_en_next;
                irq_pend_reg <= irq_pend_next;
                stamp_reg    <= stamp_next;
            end
        end
    end

endmodule

`default_nettype wire

// ----- design/cartridge_mapper_scanline_irq_pcm_top.sv -----
`default_nettype none

// Channel   Ports                        Direction  Carries
// request   s_valid, s_ready, s_item     in         write / PCM read / hblank tick
// result    m_valid, m_ready, m_item     out        PCM address, IRQ, bank registers
// config    cfg_we, cfg_wdata            in         pcm_address_mask
//
// One request per cycle sustained while m_ready keeps the result moving; an accepted
// request passes the input register, then the state update into the result register.
// Synchronous active-low reset clears valid flags and core state; mask resets to all ones.
// A stalled result holds in its register while one more request waits in the
// input register; s_ready drops only when both are full and m_ready is low.

module cartridge_mapper_scanline_irq_pcm_top
    import cmsip_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [23:0] cfg_wdata,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire in_item_t    s_item,
    output logic             m_valid,
    input  wire logic        m_ready,
    output out_item_t        m_item
);

    logic      in_valid_reg;
    in_item_t  in_item_reg;
    logic      out_valid_reg;
    out_item_t out_item_reg;
    out_item_t result;
    logic      advance;

    // Move the held request into the result register when there is room
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

    cmsip_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .fire      (advance),
        .item      (in_item_reg),
        .result    (result)
    );

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_item_reg <= result;
        end
    end

    // Checks
    a_hold_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("held request lost");

    a_advance_result: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("processed request produced no result");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && out_valid_reg && !m_ready))
        else $error("request side stalled without backpressure");

    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> (!out_valid_reg && !in_valid_reg))
        else $error("valid flags not cleared by reset");

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 100ps

module tb;
    import cmsip_pkg::*;

    // No-op request type; the block must leave all state alone
    localparam logic [1:0] REQ_NONE = 2'd3;

    localparam int unsigned N_PHASES    = 6;
    localparam int unsigned PHASE_ITEMS = 215;
    localparam int unsigned CALM_FROM   = 100;
    localparam int unsigned LONG_HOLD   = 300;
    localparam int unsigned QUIET_LIMIT = 2000;
    localparam int unsigned SETTLE      = 4;
    localparam int unsigned DRAIN       = 8;

    typedef struct packed {
        in_item_t  req;
        logic      known;
        out_item_t want;
    } dir_row_t;

    logic      aclk = 1'b0;
    logic      aresetn;
    logic      cfg_we;
    logic [23:0] cfg_wdata;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_item;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_item;

    // Mirror of the cartridge state
    logic [BANK_W-1:0]  bank_q [4];
    logic [ADDR_W-1:0]  smp_addr;
    logic [7:0]         smp_ctrl;
    logic [7:0]         line_cnt;
    logic [7:0]         line_rld;
    logic               irq_en;
    logic               irq_pend;
    logic [STAMP_W-1:0] last_stamp;
    logic [ADDR_W-1:0]  pcm_mask;

    out_item_t          cart_view_q [$];
    dir_row_t           dir_tab [$];
    logic [STAMP_W-1:0] stamp_now;
    int unsigned        mismatch_cnt;
    int unsigned        quiet_cycles;
    bit                 calm;
    bit                 long_hold;

    cartridge_mapper_scanline_irq_pcm_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

    always #4 aclk = ~aclk;

    // Apply one request to the mirror and return the view the block should report
    function automatic out_item_t cart_step(input in_item_t r);
        out_item_t v;
        logic [STAMP_W-1:0] lim;
        v.pcm_rom_address = smp_addr & pcm_mask;
        case (r.req_type)
            REQ_WRITE: begin
                if (r.cpu_address[15]) begin
                    case (r.cpu_address[14:12])
                        FN_RELOAD:   line_rld = r.write_data;
                        FN_CLEAR:    line_cnt = '0;
                        FN_IRQ_OFF: begin
                            irq_en   = 1'b0;
                            irq_pend = 1'b0;
                        end
                        FN_IRQ_ON:   irq_en = 1'b1;
                        FN_PCM_SHFT: smp_addr = {smp_addr[ADDR_W-2:0], r.write_data[7]};
                        FN_PCM_CTRL: smp_ctrl = r.write_data;
                        default:     bank_q[r.write_data[7:6]] = r.write_data[5:0];
                    endcase
                end
            end
            REQ_PCM: begin
                // guard window wraps at 32 bits
                lim = last_stamp + PCM_GUARD;
                if (r.cycle_stamp < last_stamp || r.cycle_stamp > lim) begin
                    if (smp_ctrl[1])
                        smp_addr = smp_addr + 1'b1;
                    last_stamp = r.cycle_stamp;
                end
            end
            REQ_TICK: begin
                if (line_cnt == '0)
                    line_cnt = line_rld;
                else
                    line_cnt = line_cnt - 1'b1;
                if (line_cnt == '0 && irq_en)
                    irq_pend = 1'b1;
            end
            default: ;
        endcase
        v.irq_line      = irq_pend;
        v.prg_bank_6000 = bank_q[0];
        v.prg_bank_8000 = bank_q[1];
        v.prg_bank_a000 = bank_q[2];
        v.chr_bank_low  = bank_q[3];
        return v;
    endfunction

    function automatic in_item_t wr(input logic [2:0] fn, input logic [11:0] lo,
                                    input logic [7:0] d);
        return '{REQ_WRITE, {1'b1, fn, lo}, d, 32'h0};
    endfunction

    function automatic in_item_t rd(input logic [STAMP_W-1:0] st);
        return '{REQ_PCM, 16'h0, 8'h0, st};
    endfunction

    function automatic in_item_t tk();
        return '{REQ_TICK, 16'h0, 8'h0, 32'h0};
    endfunction

    // Random request: live register writes most often, PCM reads with a creeping stamp, ticks, rare no-ops
    function automatic in_item_t rand_req();
        in_item_t r;
        logic [31:0] w;
        int unsigned k;
        k = $urandom_range(0, 99);
        w = $urandom;
        r.cpu_address = w[15:0];
        r.write_data  = w[23:16];
        r.cycle_stamp = $urandom;
        if (k < 45) begin
            r.req_type = REQ_WRITE;
            if (k >= 4)
                r.cpu_address[15] = 1'b1;
            // short reloads so the interrupt fires often
            if (r.cpu_address[14:12] == FN_RELOAD && w[24])
                r.write_data = 8'($urandom_range(0, 6));
        end else if (k < 75) begin
            r.req_type = REQ_PCM;
            case ($urandom_range(0, 9))
                0:       ;
                1:       r.cycle_stamp = 32'hFFFF_FFF0 + 32'($urandom_range(0, 15));
                default: r.cycle_stamp = stamp_now + 32'($urandom_range(0, 10));
            endcase
            stamp_now = r.cycle_stamp;
        end else if (k < 96) begin
            r.req_type = REQ_TICK;
        end else begin
            r.req_type = REQ_NONE;
        end
        return r;
    endfunction

    // Offer one request and wait for it to be taken
    task automatic send_req(input in_item_t r, input logic known, input out_item_t want);
        int unsigned gap;
        out_item_t v;
        if (!calm && !long_hold && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            gap = $urandom_range(1, 17);
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= r;
        do @(posedge aclk); while (!s_ready);
        v = cart_step(r);
        cart_view_q.push_back(known ? want : v);
    endtask

    // Mask write only once the block has drained
    task automatic set_mask(input logic [23:0] m);
        s_valid <= 1'b0;
        while (cart_view_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        pcm_mask = m;
    endtask

    task automatic chk_field(input string f, input logic [31:0] w, input logic [31:0] g);
        if (w !== g) begin
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, f, w, g);
            mismatch_cnt++;
        end
    endtask

    // Result checker
    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready) begin
            if (cart_view_q.size() == 0) begin
                $display("%0t: unexpected result: expected none, got %h", $time, m_item);
                mismatch_cnt++;
            end else begin
                chk_field("pcm_rom_address", 32'(cart_view_q[0].pcm_rom_address),
                          32'(m_item.pcm_rom_address));
                chk_field("irq_line", 32'(cart_view_q[0].irq_line),
                          32'(m_item.irq_line));
                chk_field("prg_bank_6000", 32'(cart_view_q[0].prg_bank_6000),
                          32'(m_item.prg_bank_6000));
                chk_field("prg_bank_8000", 32'(cart_view_q[0].prg_bank_8000),
                          32'(m_item.prg_bank_8000));
                chk_field("prg_bank_a000", 32'(cart_view_q[0].prg_bank_a000),
                          32'(m_item.prg_bank_a000));
                chk_field("chr_bank_low", 32'(cart_view_q[0].chr_bank_low),
                          32'(m_item.chr_bank_low));
                void'(cart_view_q.pop_front());
            end
        end
    end

    // Watchdog on cycles with no handshake on either channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // Result sink: random stall bursts, one long hold-off on request
    initial begin : result_sink
        int unsigned n;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (long_hold) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                long_hold = 1'b0;
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                n = $urandom_range(1, 17);
                repeat (n) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                n = $urandom_range(1, 24);
                repeat (n) @(posedge aclk);
            end
        end
    end

    initial begin : stimulus
        logic [23:0] masks [N_PHASES];
        aresetn      = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        s_valid      = 1'b0;
        s_item       = '0;
        mismatch_cnt = 0;
        quiet_cycles = 0;
        calm         = 1'b0;
        long_hold    = 1'b0;
        stamp_now    = '0;
        foreach (bank_q[i])
            bank_q[i] = '0;
        smp_addr   = '0;
        smp_ctrl   = '0;
        line_cnt   = '0;
        line_rld   = '0;
        irq_en     = 1'b0;
        irq_pend   = 1'b0;
        last_stamp = '0;
        pcm_mask   = MASK_RST;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: fresh-reset rows carry their expected view
        dir_tab.push_back('{'{REQ_NONE, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF}, 1'b1, '0});
        dir_tab.push_back('{wr(FN_RELOAD, 12'hFFF, 8'hFF), 1'b1, '0});
        // below 0x8000: no register
        dir_tab.push_back('{'{REQ_WRITE, 16'h7FFF, 8'hFF, 32'h0}, 1'b1, '0});
        dir_tab.push_back('{wr(FN_BANK_B, 12'h000, {BANK_CHR, 6'h3F}), 1'b1,
                            '{24'h0, 1'b0, 6'h00, 6'h00, 6'h00, 6'h3F}});
        dir_tab.push_back('{wr(FN_BANK_A, 12'h000, {BANK_6000, 6'h3F}), 1'b1,
                            '{24'h0, 1'b0, 6'h3F, 6'h00, 6'h00, 6'h3F}});
        dir_tab.push_back('{wr(FN_BANK_A, 12'hFFF, {BANK_8000, 6'h00}), 1'b0, '0});
        dir_tab.push_back('{wr(FN_BANK_B, 12'h000, {BANK_A000, 6'h2A}), 1'b0, '0});
        // scanline counter down to an interrupt
        dir_tab.push_back('{wr(FN_IRQ_ON, 12'h000, 8'h00), 1'b0, '0});
        dir_tab.push_back('{wr(FN_RELOAD, 12'h000, 8'h02), 1'b0, '0});
        dir_tab.push_back('{wr(FN_CLEAR, 12'h000, 8'h00), 1'b0, '0});
        dir_tab.push_back('{tk(), 1'b0, '0});
        dir_tab.push_back('{tk(), 1'b0, '0});
        dir_tab.push_back('{tk(), 1'b0, '0});
        // enable again keeps the pending interrupt
        dir_tab.push_back('{wr(FN_IRQ_ON, 12'hFFF, 8'h00), 1'b0, '0});
        dir_tab.push_back('{tk(), 1'b0, '0});
        dir_tab.push_back('{wr(FN_IRQ_OFF, 12'h000, 8'h00), 1'b0, '0});
        // serial sample address and auto-increment
        dir_tab.push_back('{wr(FN_PCM_SHFT, 12'h000, 8'h80), 1'b0, '0});
        dir_tab.push_back('{wr(FN_PCM_SHFT, 12'h000, 8'h7F), 1'b0, '0});
        dir_tab.push_back('{wr(FN_PCM_SHFT, 12'h000, 8'hFF), 1'b0, '0});
        dir_tab.push_back('{wr(FN_PCM_CTRL, 12'h000, 8'h02), 1'b0, '0});
        dir_tab.push_back('{rd(32'd0), 1'b0, '0});
        dir_tab.push_back('{rd(32'd7), 1'b0, '0});
        dir_tab.push_back('{rd(32'd3), 1'b0, '0});
        // guard window across the stamp wrap
        dir_tab.push_back('{rd(32'hFFFF_FFFD), 1'b0, '0});
        dir_tab.push_back('{rd(32'hFFFF_FFFE), 1'b0, '0});
        dir_tab.push_back('{rd(32'd2), 1'b0, '0});
        dir_tab.push_back('{wr(FN_PCM_CTRL, 12'h000, 8'hFD), 1'b0, '0});
        dir_tab.push_back('{rd(32'd100), 1'b0, '0});
        foreach (dir_tab[i])
            send_req(dir_tab[i].req, dir_tab[i].known, dir_tab[i].want);

        // Random phases, one mask setting each
        masks[0] = 24'h00_0000;
        masks[1] = 24'hFF_FFFF;
        masks[2] = 24'h00_FFFF;
        masks[3] = 24'h00_03FF;
        masks[4] = 24'($urandom);
        masks[5] = 24'hFF_FFFF;
        for (int ph = 0; ph < N_PHASES; ph++) begin
            set_mask(masks[ph]);
            // receiver backs off while requests keep coming
            if (ph == 1)
                long_hold = 1'b1;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (ph == N_PHASES - 1 && i == CALM_FROM)
                    calm = 1'b1;
                send_req(rand_req(), 1'b0, '0);
            end
        end
        s_valid <= 1'b0;

        while (cart_view_q.size() != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
        if (mismatch_cnt == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
